// ===== hw/rtl/huffman_tree_load_and_decode_assert.svh =====
// Assertion macros used by the Huffman tree load and decode top level.
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_ASSERT_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_ASSERT_SVH

`ifndef SYNTHESIS
`define HTLD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("htld assertion failed");
`define HTLD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("htld assertion failed");
`else
`define HTLD_ASSERT_IMP(lbl, ante, cons)
`define HTLD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/htld_pkg.sv =====
// Types and constants of the Huffman tree load and decode block.
`default_nettype none

package htld_pkg;

    localparam int SYM_PORT_W  = 8;
    localparam int STACK_DEPTH = 255;
    localparam int STACK_CNT_W = 8;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_EMIT,
        BS_READ,
        BS_PATCH
    } t_bstage;

endpackage

`default_nettype wire

// ===== hw/rtl/huffman_tree_load_and_decode.sv =====
// Top level of the Huffman decoder with pre-order code tree loading.
`default_nettype none

// Load items (op 0) store the code tree in pre-order into a node table RAM;
// a stack RAM holds open internal nodes still lacking a one-child; a leaf load
// pops one and patches that parent. Decode items (op 1) carry one code bit; each
// bit moves the walk one level and a reached leaf yields its symbol. Decode
// items and internal-node loads are taken one per cycle while the output queue
// has room: the current node is held in a register and the single node-table
// read of the child returns in the next cycle, forwarded to the next bit. A
// leaf load that closes an open node stalls the input for a patch step: the
// patch needs the stack read and a second write on the one node-table write
// port. A symbol passes the second-stage register and the two-entry output
// queue, which keeps input and output apart. There is no clearing pass after
// reset: table and stack entries hold nothing defined until loaded.
module huffman_tree_load_and_decode
    import htld_pkg::*;
#(
    parameter int MAX_NODES   = 511,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_op,
    input  wire logic                  i_node_internal,
    input  wire logic [SYM_PORT_W-1:0] i_leaf_symbol,
    input  wire logic                  i_code_bit,
    input  wire logic                  i_restart,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [SYM_PORT_W-1:0] o_symbol
);

    `include "huffman_tree_load_and_decode_assert.svh"

    localparam int W_IDX   = $clog2(MAX_NODES);
    localparam int LIDX_W  = $clog2(MAX_NODES + 1);
    localparam int SYM_W   = (SYMBOL_BITS < SYM_PORT_W) ? SYMBOL_BITS : SYM_PORT_W;
    localparam int PAY_W   = (LIDX_W > SYM_W) ? LIDX_W : SYM_W;
    localparam int ENTRY_W = PAY_W + 1;
    localparam int STK_AW  = $clog2(STACK_DEPTH);

    t_bstage                 r_bs, n_bs;
    logic [W_IDX-1:0]        r_walk, n_walk;
    logic [ENTRY_W-1:0]      r_cur, n_cur;
    logic [ENTRY_W-1:0]      r_root, n_root;
    logic [LIDX_W-1:0]       r_load_idx, n_load_idx;
    logic [STACK_CNT_W-1:0]  r_stack_cnt, n_stack_cnt;
    logic [LIDX_W-1:0]       r_b_child, n_b_child;
    logic [SYM_PORT_W-1:0]   r_b_sym, n_b_sym;
    logic [1:0]              r_q_cnt, n_q_cnt;
    logic [SYM_PORT_W-1:0]   r_q0, n_q0;
    logic [SYM_PORT_W-1:0]   r_q1, n_q1;

    logic                    accept;
    logic                    pop;
    logic                    push;
    logic [SYM_PORT_W-1:0]   push_sym;
    logic [1:0]              q_after;
    logic                    b_may_push;

    logic [W_IDX-1:0]        eff_walk;
    logic [ENTRY_W-1:0]      eff_cur;
    logic [W_IDX-1:0]        dec_walk;
    logic [ENTRY_W-1:0]      dec_cur;
    logic [LIDX_W-1:0]       dec_child;
    logic                    dec_emit;
    logic [SYM_PORT_W-1:0]   dec_sym;
    logic [LIDX_W-1:0]       ld_k;
    logic [STACK_CNT_W-1:0]  ld_cnt;
    logic                    ld_ok;

    logic                    node_we;
    logic [W_IDX-1:0]        node_waddr;
    logic [ENTRY_W-1:0]      node_wdata;
    logic [W_IDX-1:0]        node_raddr;
    logic [ENTRY_W-1:0]      node_rdata;
    logic                    stack_we;
    logic [STK_AW-1:0]       stack_waddr;
    logic [W_IDX-1:0]        stack_wdata;
    logic [STK_AW-1:0]       stack_raddr;
    logic [W_IDX-1:0]        stack_rdata;

    htld_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    htld_ram #(
        .WIDTH (W_IDX),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (stack_wdata),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    // output queue handshake
    assign o_valid    = (r_q_cnt != 2'd0);
    assign o_symbol   = r_q0;
    assign pop        = o_valid && !i_stall;
    assign q_after    = r_q_cnt - {1'b0, pop};
    assign b_may_push = (r_bs == BS_EMIT) || (r_bs == BS_READ);
    assign o_stall    = (r_bs == BS_PATCH) || ((q_after + {1'b0, b_may_push}) > 2'd1);
    assign accept     = i_valid && !o_stall;

    // forward the walk from a child read in flight
    always_comb begin
        eff_walk = r_walk;
        eff_cur  = r_cur;
        if (r_bs == BS_READ) begin
            if (node_rdata[ENTRY_W-1]) begin
                eff_walk = r_b_child[W_IDX-1:0];
                eff_cur  = node_rdata;
            end else begin
                eff_walk = '0;
                eff_cur  = r_root;
            end
        end
    end

    always_comb begin
        push     = 1'b0;
        push_sym = r_b_sym;
        case (r_bs)
            BS_EMIT: begin
                push = 1'b1;
            end
            BS_READ: begin
                push     = !node_rdata[ENTRY_W-1];
                push_sym = SYM_PORT_W'(node_rdata[SYM_W-1:0]);
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    // decode step: current node, child and early emit; load index and stack count
    always_comb begin
        dec_walk  = i_restart ? '0 : eff_walk;
        dec_cur   = i_restart ? r_root : eff_cur;
        dec_child = i_code_bit ? dec_cur[LIDX_W-1:0] : (LIDX_W'(dec_walk) + 1'b1);
        dec_sym   = '0;
        dec_emit  = 1'b0;
        if (!dec_cur[ENTRY_W-1]) begin
            dec_emit = 1'b1;
            dec_sym  = SYM_PORT_W'(dec_cur[SYM_W-1:0]);
        end else if (dec_child >= LIDX_W'(MAX_NODES)) begin
            dec_emit = 1'b1;
        end
        ld_k   = i_restart ? '0 : r_load_idx;
        ld_cnt = i_restart ? '0 : r_stack_cnt;
        ld_ok  = (ld_k < LIDX_W'(MAX_NODES));
    end

    // second stage selection
    always_comb begin
        n_bs = BS_IDLE;
        if (accept) begin
            if (i_op == OP_DECODE) begin
                n_bs = dec_emit ? BS_EMIT : BS_READ;
            end else if (ld_ok && !i_node_internal && (ld_cnt != '0)) begin
                n_bs = BS_PATCH;
            end
        end
    end

    always_comb begin
        n_walk      = eff_walk;
        n_cur       = eff_cur;
        n_root      = r_root;
        n_load_idx  = r_load_idx;
        n_stack_cnt = r_stack_cnt;
        n_b_child   = r_b_child;
        n_b_sym     = r_b_sym;
        node_we     = 1'b0;
        node_waddr  = '0;
        node_wdata  = '0;
        node_raddr  = '0;
        stack_we    = 1'b0;
        stack_waddr = r_stack_cnt[STK_AW-1:0];
        stack_wdata = '0;
        stack_raddr = STK_AW'(r_stack_cnt - 1'b1);
        if (r_bs == BS_PATCH) begin
            node_we    = 1'b1;
            node_waddr = stack_rdata;
            node_wdata = {1'b1, PAY_W'(r_b_child)};
            if (stack_rdata == r_walk) begin
                n_cur = node_wdata;
            end
            if (stack_rdata == '0) begin
                n_root = node_wdata;
            end
        end
        if (accept) begin
            if (i_op == OP_LOAD) begin
                n_stack_cnt = ld_cnt;
                n_load_idx  = ld_k;
                if (i_restart) begin
                    n_walk = '0;
                    n_cur  = r_root;
                end
                if (ld_ok) begin
                    node_we    = 1'b1;
                    node_waddr = ld_k[W_IDX-1:0];
                    node_wdata = i_node_internal ? {1'b1, PAY_W'(0)}
                                                 : {1'b0, PAY_W'(i_leaf_symbol[SYM_W-1:0])};
                    if (node_waddr == n_walk) begin
                        n_cur = node_wdata;
                    end
                    if (node_waddr == '0) begin
                        n_root = node_wdata;
                    end
                    n_load_idx = ld_k + 1'b1;
                    if (i_node_internal) begin
                        if (ld_cnt < STACK_CNT_W'(STACK_DEPTH)) begin
                            stack_we    = 1'b1;
                            stack_waddr = ld_cnt[STK_AW-1:0];
                            stack_wdata = ld_k[W_IDX-1:0];
                            n_stack_cnt = ld_cnt + 1'b1;
                        end
                    end else if (ld_cnt != '0) begin
                        stack_raddr = STK_AW'(ld_cnt - 1'b1);
                        n_stack_cnt = ld_cnt - 1'b1;
                        n_b_child   = ld_k + 1'b1;
                    end
                end
            end else begin
                n_b_sym = dec_sym;
                if (dec_emit) begin
                    n_walk = '0;
                    n_cur  = r_root;
                end else begin
                    node_raddr = dec_child[W_IDX-1:0];
                    n_b_child  = dec_child;
                    n_walk     = dec_walk;
                    n_cur      = dec_cur;
                end
            end
        end
    end

    always_comb begin
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (pop) begin
            n_q0 = r_q1;
        end
        if (push) begin
            if (q_after == 2'd0) begin
                n_q0 = push_sym;
            end else begin
                n_q1 = push_sym;
            end
        end
        n_q_cnt = q_after + {1'b0, push};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs        <= BS_IDLE;
            r_walk      <= '0;
            r_load_idx  <= '0;
            r_stack_cnt <= '0;
            r_q_cnt     <= 2'd0;
        end else begin
            r_bs        <= n_bs;
            r_walk      <= n_walk;
            r_load_idx  <= n_load_idx;
            r_stack_cnt <= n_stack_cnt;
            r_q_cnt     <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_root    <= n_root;
        r_b_child <= n_b_child;
        r_b_sym   <= n_b_sym;
        r_q0      <= n_q0;
        r_q1      <= n_q1;
    end

    `HTLD_ASSERT_IMP(a_queue_bound, 1'b1, r_q_cnt != 2'd3)
    `HTLD_ASSERT_NXT(a_patch_single, r_bs == BS_PATCH, r_bs == BS_IDLE)
    `HTLD_ASSERT_NXT(a_emit_shows, r_bs == BS_EMIT, o_valid)
    `HTLD_ASSERT_IMP(a_walk_range, 1'b1, LIDX_W'(r_walk) < LIDX_W'(MAX_NODES))
    `HTLD_ASSERT_IMP(a_stack_range, 1'b1, r_stack_cnt <= STACK_CNT_W'(STACK_DEPTH))

endmodule

`default_nettype wire

// ===== hw/rtl/htld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module htld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== bench/tb_huffman_tree_load_and_decode.sv =====
// Testbench for the Huffman tree load and decode block: random pre-order trees and code bits.
module tb_huffman_tree_load_and_decode;
    import htld_pkg::*;

    localparam int MAX_NODES = 511;

    typedef struct packed {
        logic                  op;
        logic                  inner;
        logic [SYM_PORT_W-1:0] sym;
        logic                  code;
        logic                  restart;
    } coded_item_t;

    typedef struct packed {
        logic       inner;
        logic [8:0] payload;
    } tree_node_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_op = OP_LOAD;
    logic                  i_node_internal = 1'b0;
    logic [SYM_PORT_W-1:0] i_leaf_symbol = '0;
    logic                  i_code_bit = 1'b0;
    logic                  i_restart = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [SYM_PORT_W-1:0] o_symbol;

    coded_item_t           pending[$];
    coded_item_t           head_item;
    logic [SYM_PORT_W-1:0] decoded_syms[$];
    logic [SYM_PORT_W-1:0] want_sym;
    tree_node_t            tree_mem[MAX_NODES];
    logic [8:0]            open_nodes[STACK_DEPTH];
    logic [STACK_CNT_W-1:0] open_cnt = '0;
    logic [8:0]            next_slot = '0;
    logic [8:0]            walk_at = '0;
    int                    queued_cnt = 0;
    int                    accepted_cnt = 0;
    int                    fail_cnt = 0;
    int                    idle_pct = 0;
    int                    stall_pct = 0;

    huffman_tree_load_and_decode #(
        .MAX_NODES  (MAX_NODES),
        .SYMBOL_BITS(8)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_node_internal(i_node_internal),
        .i_leaf_symbol  (i_leaf_symbol),
        .i_code_bit     (i_code_bit),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_symbol       (o_symbol)
    );

    always #2 i_clk = ~i_clk;

    function automatic tree_node_t fetch_node(logic [9:0] idx);
        if (idx >= MAX_NODES) return '0;
        return tree_mem[idx];
    endfunction

    task automatic decoder_step(coded_item_t it);
        tree_node_t cur;
        tree_node_t nxt;
        logic [9:0] child;
        if (it.op == OP_LOAD) begin
            if (it.restart) begin
                next_slot = '0;
                open_cnt  = '0;
                walk_at   = '0;
            end
            if (next_slot < MAX_NODES) begin
                if (it.inner) begin
                    tree_mem[next_slot] = {1'b1, 9'd0};
                    if (open_cnt < STACK_DEPTH) begin
                        open_nodes[open_cnt] = next_slot;
                        open_cnt++;
                    end
                end else begin
                    tree_mem[next_slot] = {1'b0, 1'b0, it.sym};
                    if (open_cnt > 0) begin
                        open_cnt--;
                        tree_mem[open_nodes[open_cnt]] = {1'b1, next_slot + 9'd1};
                    end
                end
                next_slot++;
            end
        end else begin
            if (it.restart) walk_at = '0;
            cur = fetch_node({1'b0, walk_at});
            if (!cur.inner) begin
                decoded_syms.push_back(cur.payload[7:0]);
                walk_at = '0;
            end else begin
                child = it.code ? {1'b0, cur.payload} : {1'b0, walk_at} + 10'd1;
                nxt = fetch_node(child);
                if (!nxt.inner) begin
                    decoded_syms.push_back(nxt.payload[7:0]);
                    walk_at = '0;
                end else begin
                    walk_at = child[8:0];
                end
            end
        end
    endtask

    task automatic queue_load(logic inner, logic [7:0] sym, logic restart);
        pending.push_back({OP_LOAD, inner, sym, 1'($urandom_range(1)), restart});
        queued_cnt++;
    endtask

    task automatic queue_bit(logic code, logic restart);
        pending.push_back({OP_DECODE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                           code, restart});
        queued_cnt++;
    endtask

    task automatic queue_walk(int count);
        repeat (count) queue_bit(1'($urandom_range(1)), $urandom_range(9) == 0);
    endtask

    task automatic queue_tree(int leaves, logic restart);
        int split;
        if (leaves == 1) begin
            queue_load(1'b0, 8'($urandom_range(255)), restart);
        end else begin
            split = $urandom_range(leaves - 1, 1);
            queue_load(1'b1, 8'($urandom_range(255)), restart);
            queue_tree(split, 1'b0);
            queue_tree(leaves - split, 1'b0);
        end
    endtask

    task automatic settle();
        while (accepted_cnt != queued_cnt || decoded_syms.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                accepted_cnt++;
                decoder_step({i_op, i_node_internal, i_leaf_symbol, i_code_bit, i_restart});
            end
            if (!i_valid || !o_stall) begin
                if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    head_item = pending.pop_front();
                    i_op            <= head_item.op;
                    i_node_internal <= head_item.inner;
                    i_leaf_symbol   <= head_item.sym;
                    i_code_bit      <= head_item.code;
                    i_restart       <= head_item.restart;
                    i_valid         <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (decoded_syms.size() == 0) begin
                    if (fail_cnt < 10) $display("unexpected symbol %02h", o_symbol);
                    fail_cnt++;
                end else begin
                    want_sym = decoded_syms.pop_front();
                    if (o_symbol !== want_sym) begin
                        if (fail_cnt < 10) begin
                            $display("symbol mismatch: expected %02h, got %02h",
                                     want_sym, o_symbol);
                        end
                        fail_cnt++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        int leaves;
        int n;
        int made;
        int idle_by_phase[4];
        int stall_by_phase[4];
        idle_by_phase  = '{0, 63, 0, 26};
        stall_by_phase = '{0, 0, 63, 26};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_load(1'b0, 8'hFF, 1'b1);
        queue_bit(1'b0, 1'b0);
        queue_bit(1'b1, 1'b1);
        queue_load(1'b1, 8'($urandom_range(255)), 1'b1);
        queue_load(1'b0, 8'h00, 1'b0);
        queue_load(1'b1, 8'($urandom_range(255)), 1'b0);
        queue_load(1'b0, 8'hA5, 1'b0);
        queue_load(1'b0, 8'h5A, 1'b0);
        queue_bit(1'b0, 1'b0);
        queue_bit(1'b1, 1'b0);
        queue_bit(1'b0, 1'b0);
        queue_bit(1'b1, 1'b0);
        queue_bit(1'b1, 1'b0);
        queue_bit(1'b1, 1'b0);
        queue_bit(1'b0, 1'b1);
        queue_load(1'b0, 8'h33, 1'b0);
        queue_bit(1'b1, 1'b0);
        queue_bit(1'b1, 1'b0);
        settle();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            made = 0;
            while (made < 80) begin
                n = $urandom_range(99);
                if (n < 70) begin
                    leaves = ($urandom_range(9) == 0) ? $urandom_range(64, 13)
                                                      : $urandom_range(12, 2);
                    queue_tree(leaves, 1'b1);
                    made += 2 * leaves - 1;
                end else if (n < 85) begin
                    repeat ($urandom_range(4, 1)) begin
                        queue_load(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0);
                    end
                end else begin
                    queue_load(1'b1, 8'($urandom_range(255)), 1'b1);
                    repeat ($urandom_range(5, 0)) begin
                        queue_load(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0);
                    end
                    leaves = $urandom_range(12, 2);
                    queue_tree(leaves, 1'b1);
                    made += 2 * leaves - 1;
                end
                n = $urandom_range(40, 8);
                queue_walk(n);
                made += n;
            end
            settle();
        end

        repeat (16) @(posedge i_clk);
        if (fail_cnt == 0 && decoded_syms.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #1600000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/htld_pkg.sv
hw/rtl/htld_ram.sv
hw/rtl/huffman_tree_load_and_decode.sv
bench/tb_huffman_tree_load_and_decode.sv
